// File: rtl/rbp_pkg.sv
// Shared types and constants of the replicate-border padding frame store.
// Holds the channel word structs, the internal command word and size constants.
// No dependencies.
package rbp_pkg;

  // Frame store geometry
  localparam int MAX_WIDTH  = 512;
  localparam int MAX_HEIGHT = 512;
  localparam int MAX_WINDOW = 31;

  // Fixed field widths of the channels
  localparam int COORD_W     = 10;
  localparam int PIXEL_W     = 8;
  localparam int SIZE_W      = 10;
  localparam int WIN_W       = 5;
  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = 10;

  // Store addressing: row bits above column bits
  localparam int X_W         = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int Y_W         = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
  localparam int ADDR_W      = X_W + Y_W;
  localparam int FRAME_DEPTH = 1 << ADDR_W;

  // Width of the coordinate arithmetic in the front end
  localparam int MAX_DIM = (MAX_WIDTH > MAX_HEIGHT) ? MAX_WIDTH : MAX_HEIGHT;
  localparam int CALC_W  = $clog2(MAX_DIM + MAX_WINDOW + (1 << COORD_W)) + 1;

  // Queue sizes
  localparam int CMD_DEPTH  = 4;
  localparam int CMD_PTR_W  = $clog2(CMD_DEPTH);
  localparam int CMD_CNT_W  = $clog2(CMD_DEPTH + 1);
  localparam int RSP_DEPTH  = 2;
  localparam int RSP_PTR_W  = $clog2(RSP_DEPTH);
  localparam int RSP_CNT_W  = $clog2(RSP_DEPTH + 1);

  // Register indexes
  localparam logic [CFG_INDEX_W-1:0] CFG_SRC_COLS    = CFG_INDEX_W'(0);
  localparam logic [CFG_INDEX_W-1:0] CFG_SRC_ROWS    = CFG_INDEX_W'(1);
  localparam logic [CFG_INDEX_W-1:0] CFG_WINDOW_SIZE = CFG_INDEX_W'(2);

  // Request function codes
  localparam logic FUNC_WRITE = 1'b0;
  localparam logic FUNC_READ  = 1'b1;

  typedef struct packed {
    logic               func;
    logic [COORD_W-1:0] column;
    logic [COORD_W-1:0] line;
    logic [PIXEL_W-1:0] pixel_in;
  } req_t;

  typedef struct packed {
    logic [PIXEL_W-1:0] pixel_out;
    logic               outside;
  } rsp_t;

  // Classified command handed from front end to back end
  typedef struct packed {
    logic               is_read;
    logic               outside;
    logic [ADDR_W-1:0]  addr;
    logic [PIXEL_W-1:0] wdata;
  } cmd_t;

  // Back end occupancy, watched at the top level
  typedef struct packed {
    logic [RSP_CNT_W-1:0] rsp_count;
    logic                 load_busy;
  } back_status_t;

endpackage

// File: rtl/rbp_ram.sv
// Generic single-port RAM with registered read data.
// Used for the frame store; no dependencies.
module rbp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     en,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write or read one word per cycle
  always_ff @(posedge clk) begin
    if (en) begin
      if (we) begin
        mem[addr] <= wdata;
      end else begin
        rdata <= mem[addr];
      end
    end
  end

endmodule

// File: rtl/rbp_front.sv
// Front end: configuration registers, request intake and coordinate classification.
// Depends on rbp_pkg.
module rbp_front import rbp_pkg::*; (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   req_valid,
  output logic                   req_ready,
  input  req_t                   req,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  input  logic                   cmd_full,
  output logic                   cmd_push,
  output cmd_t                   cmd
);

  logic [SIZE_W-1:0] src_cols;
  logic [SIZE_W-1:0] src_rows;
  logic [WIN_W-1:0]  window_size;

  logic [CALC_W-1:0] w, h, k, pad, w_lim, h_lim;
  logic [CALC_W-1:0] col, row, col_off, row_off, sx, sy;
  logic              is_read, outside, write_ok;

  function automatic logic [CALC_W-1:0] sat_size(input logic [CALC_W-1:0] v,
                                                 input logic [CALC_W-1:0] hi);
    logic [CALC_W-1:0] r;
    if (v == '0) begin
      r = CALC_W'(1);
    end else if (v > hi) begin
      r = hi;
    end else begin
      r = v;
    end
    return r;
  endfunction

  assign cfg_ready = 1'b1;

  // Hold the configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      src_cols    <= SIZE_W'(512);
      src_rows    <= SIZE_W'(512);
      window_size <= WIN_W'(3);
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_SRC_COLS:    src_cols    <= cfg_data[SIZE_W-1:0];
        CFG_SRC_ROWS:    src_rows    <= cfg_data[SIZE_W-1:0];
        CFG_WINDOW_SIZE: window_size <= cfg_data[WIN_W-1:0];
        default: ;
      endcase
    end
  end

  // Classify the request: range checks and clamp to the image edges
  always_comb begin
    w       = sat_size(CALC_W'(src_cols), CALC_W'(MAX_WIDTH));
    h       = sat_size(CALC_W'(src_rows), CALC_W'(MAX_HEIGHT));
    k       = sat_size(CALC_W'(window_size), CALC_W'(MAX_WINDOW));
    pad     = k >> 1;
    w_lim   = w + k - CALC_W'(1);
    h_lim   = h + k - CALC_W'(1);
    col     = CALC_W'(req.column);
    row     = CALC_W'(req.line);
    col_off = col - pad;
    row_off = row - pad;

    if (col < pad) begin
      sx = '0;
    end else if (col_off >= w) begin
      sx = w - CALC_W'(1);
    end else begin
      sx = col_off;
    end

    if (row < pad) begin
      sy = '0;
    end else if (row_off >= h) begin
      sy = h - CALC_W'(1);
    end else begin
      sy = row_off;
    end

    is_read  = (req.func == FUNC_READ);
    outside  = (col >= w_lim) || (row >= h_lim);
    write_ok = (col < w) && (row < h);

    cmd.is_read = is_read;
    cmd.outside = is_read && outside;
    cmd.wdata   = req.pixel_in;
    if (is_read) begin
      cmd.addr = {sy[Y_W-1:0], sx[X_W-1:0]};
    end else begin
      cmd.addr = {row[Y_W-1:0], col[X_W-1:0]};
    end
  end

  // Drop writes beyond the source image; everything else goes to the queue
  assign req_ready = !cmd_full;
  assign cmd_push  = req_valid && req_ready && (is_read || write_ok);

endmodule

// File: rtl/rbp_cmd_fifo.sv
// Command queue between front end and back end.
// Depends on rbp_pkg.
module rbp_cmd_fifo import rbp_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  cmd_t din,
  output logic full,
  input  logic pop,
  output logic valid,
  output cmd_t dout
);

  cmd_t                 entries [CMD_DEPTH];
  logic [CMD_PTR_W-1:0] wr_ptr, rd_ptr;
  logic [CMD_CNT_W-1:0] count;

  function automatic logic [CMD_PTR_W-1:0] ptr_inc(input logic [CMD_PTR_W-1:0] p);
    logic [CMD_PTR_W-1:0] r;
    if (p == CMD_PTR_W'(CMD_DEPTH - 1)) begin
      r = '0;
    end else begin
      r = p + CMD_PTR_W'(1);
    end
    return r;
  endfunction

  assign full  = (count == CMD_CNT_W'(CMD_DEPTH));
  assign valid = (count != '0);
  assign dout  = entries[rd_ptr];

  // Store pushed words
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= din;
    end
  end

  // Advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= ptr_inc(wr_ptr);
      end
      if (pop) begin
        rd_ptr <= ptr_inc(rd_ptr);
      end
      count <= count + CMD_CNT_W'(push) - CMD_CNT_W'(pop);
    end
  end

endmodule

// File: rtl/rbp_back.sv
// Back end: executes commands on the frame store and buffers responses.
// Depends on rbp_pkg and rbp_ram.
module rbp_back import rbp_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  input  logic         cmd_valid,
  input  cmd_t         cmd,
  output logic         cmd_pop,
  output logic         rsp_valid,
  input  logic         rsp_ready,
  output rsp_t         rsp,
  output back_status_t status
);

  rsp_t                 rsp_buf [RSP_DEPTH];
  logic [RSP_PTR_W-1:0] rsp_head, rsp_tail;
  logic [RSP_CNT_W-1:0] rsp_count;
  logic [RSP_CNT_W:0]   rsp_occ;
  logic                 load_busy, load_outside;
  logic                 rsp_pop, rsp_room;
  logic                 ram_en, ram_we;
  logic [PIXEL_W-1:0]   ram_rdata;
  rsp_t                 load_rsp;

  function automatic logic [RSP_PTR_W-1:0] ptr_inc(input logic [RSP_PTR_W-1:0] p);
    logic [RSP_PTR_W-1:0] r;
    if (p == RSP_PTR_W'(RSP_DEPTH - 1)) begin
      r = '0;
    end else begin
      r = p + RSP_PTR_W'(1);
    end
    return r;
  endfunction

  // Issue a read only if its response is sure to find a slot
  assign rsp_pop  = rsp_valid && rsp_ready;
  assign rsp_occ  = (RSP_CNT_W+1)'(rsp_count) + (RSP_CNT_W+1)'(load_busy)
                    - (RSP_CNT_W+1)'(rsp_pop);
  assign rsp_room = (rsp_occ < (RSP_CNT_W+1)'(RSP_DEPTH));
  assign cmd_pop  = cmd_valid && (!cmd.is_read || rsp_room);
  assign ram_en   = cmd_pop && !(cmd.is_read && cmd.outside);
  assign ram_we   = cmd_pop && !cmd.is_read;

  rbp_ram #(
    .WIDTH (PIXEL_W),
    .DEPTH (FRAME_DEPTH)
  ) u_frame_store (
    .clk   (clk),
    .en    (ram_en),
    .we    (ram_we),
    .addr  (cmd.addr),
    .wdata (cmd.wdata),
    .rdata (ram_rdata)
  );

  // Track reads waiting on the store
  always_ff @(posedge clk) begin
    if (rst) begin
      load_busy <= 1'b0;
    end else begin
      load_busy <= cmd_pop && cmd.is_read;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_pop) begin
      load_outside <= cmd.outside;
    end
  end

  // Form the response: out-of-image reads give zero
  always_comb begin
    load_rsp.outside   = load_outside;
    load_rsp.pixel_out = load_outside ? '0 : ram_rdata;
  end

  // Response buffer
  always_ff @(posedge clk) begin
    if (load_busy) begin
      rsp_buf[rsp_tail] <= load_rsp;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_head  <= '0;
      rsp_tail  <= '0;
      rsp_count <= '0;
    end else begin
      if (load_busy) begin
        rsp_tail <= ptr_inc(rsp_tail);
      end
      if (rsp_pop) begin
        rsp_head <= ptr_inc(rsp_head);
      end
      rsp_count <= rsp_count + RSP_CNT_W'(load_busy) - RSP_CNT_W'(rsp_pop);
    end
  end

  assign rsp_valid = (rsp_count != '0);
  assign rsp       = rsp_buf[rsp_head];

  assign status.rsp_count = rsp_count;
  assign status.load_busy = load_busy;

endmodule

// File: rtl/replicate_border_padding.sv
// Top level of the replicate-border padding frame store.
// Depends on rbp_pkg, rbp_front, rbp_cmd_fifo and rbp_back.
//
// Frame store with clamp-to-edge padding for a square filter window. A req
// word with func write stores one grey pixel of the source image; one with
// func read names a coordinate in the padded image and returns one rsp word
// with the nearest source pixel, or zero with outside set when the
// coordinate lies beyond the padded image. Writes outside the source image
// are dropped. The block takes one req word per clock while the command
// queue is not full and returns one rsp word per clock for a stream of reads
// while rsp_ready is held, limited by the single port of the frame store,
// which does one write or one read each cycle. A read passes a four-word
// command queue, the registered read of the frame store and a two-word
// response buffer before its rsp word is valid. The frame store is
// not cleared at reset; read only pixels that were written. Configuration
// writes are taken at any time but must only be made while the block is idle.
module replicate_border_padding import rbp_pkg::*; (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   req_valid,
  output logic                   req_ready,
  input  req_t                   req,
  output logic                   rsp_valid,
  input  logic                   rsp_ready,
  output rsp_t                   rsp,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data
);

  logic         cmd_full, cmd_push, cmd_pop, cmd_valid;
  cmd_t         cmd_in, cmd_out;
  back_status_t status;

  rbp_front u_front (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req       (req),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cmd_full  (cmd_full),
    .cmd_push  (cmd_push),
    .cmd       (cmd_in)
  );

  rbp_cmd_fifo u_cmd_fifo (
    .clk   (clk),
    .rst   (rst),
    .push  (cmd_push),
    .din   (cmd_in),
    .full  (cmd_full),
    .pop   (cmd_pop),
    .valid (cmd_valid),
    .dout  (cmd_out)
  );

  rbp_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd       (cmd_out),
    .cmd_pop   (cmd_pop),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp),
    .status    (status)
  );

  // A read in flight never lands on a full response buffer
  a_rsp_no_overflow: assert property (@(posedge clk) disable iff (rst)
    !(status.load_busy && status.rsp_count == RSP_CNT_W'(RSP_DEPTH) &&
      !(rsp_valid && rsp_ready)))
    else $error("response buffer overflow");

  // Reset empties the response side
  a_reset_empty: assert property (@(posedge clk) rst |=> !rsp_valid)
    else $error("response valid after reset");

  // Out-of-image reads return zero
  a_outside_zero: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && rsp.outside) |-> (rsp.pixel_out == '0))
    else $error("outside read with nonzero pixel");

endmodule

// File: verif/padded_read_checker.sv
// Checker for the replicate-border padding frame store: watches all three channels.
// Keeps its own geometry registers and store image, predicts each read and compares.
// Depends on rbp_pkg.
module padded_read_checker import rbp_pkg::*; (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   req_valid,
  input  logic                   req_ready,
  input  req_t                   req,
  input  logic                   rsp_valid,
  input  logic                   rsp_ready,
  input  rsp_t                   rsp,
  input  logic                   cfg_valid,
  input  logic                   cfg_ready,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  output int unsigned            mismatches,
  output int unsigned            reads_waiting,
  output int unsigned            reads_checked,
  output int unsigned            border_reads
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int RESET_WINDOW = 3;

  logic [SIZE_W-1:0]  width_reg;
  logic [SIZE_W-1:0]  height_reg;
  logic [WIN_W-1:0]   window_reg;
  logic [PIXEL_W-1:0] shadow_store [FRAME_DEPTH];
  rsp_t               read_expect_q [$];
  int unsigned        fail_count = 0;
  int unsigned        checked_count = 0;
  int unsigned        border_count = 0;

  assign mismatches    = fail_count;
  assign reads_checked = checked_count;
  assign border_reads  = border_count;

  function automatic int unsigned saturate(int unsigned v, int unsigned hi);
    if (v < 1) return 1;
    if (v > hi) return hi;
    return v;
  endfunction

  // Map a padded coordinate onto the nearest source coordinate
  function automatic int unsigned clamp_edge(int unsigned p, int unsigned pad,
                                             int unsigned size);
    if (p < pad) return 0;
    if (p - pad >= size) return size - 1;
    return p - pad;
  endfunction

  always @(posedge clk) begin : track
    rsp_t        want;
    int unsigned w;
    int unsigned h;
    int unsigned k;
    int unsigned pad;
    w   = saturate(width_reg, MAX_WIDTH);
    h   = saturate(height_reg, MAX_HEIGHT);
    k   = saturate(window_reg, MAX_WINDOW);
    pad = k / 2;
    if (rst) begin
      width_reg  = SIZE_W'(MAX_WIDTH);
      height_reg = SIZE_W'(MAX_HEIGHT);
      window_reg = WIN_W'(RESET_WINDOW);
    end else begin
      // Compare the response word against the oldest pending read
      if (rsp_valid && rsp_ready) begin
        if (read_expect_q.size() == 0) begin
          $error("response word with no read waiting: pixel_out %0d outside %0b",
                 rsp.pixel_out, rsp.outside);
          fail_count++;
        end else begin
          want = read_expect_q.pop_front();
          checked_count++;
          if (want.outside) border_count++;
          if (rsp.pixel_out !== want.pixel_out) begin
            $error("pixel_out: expected %0d, actual %0d", want.pixel_out, rsp.pixel_out);
            fail_count++;
          end
          if (rsp.outside !== want.outside) begin
            $error("outside: expected %0b, actual %0b", want.outside, rsp.outside);
            fail_count++;
          end
        end
      end
      // Store writes inside the image, predict reads
      if (req_valid && req_ready) begin
        if (req.func == FUNC_WRITE) begin
          if (req.column < w && req.line < h)
            shadow_store[req.line * MAX_WIDTH + req.column] = req.pixel_in;
        end else if (req.column >= w + k - 1 || req.line >= h + k - 1) begin
          want.pixel_out = '0;
          want.outside   = 1'b1;
          read_expect_q.push_back(want);
        end else begin
          want.pixel_out = shadow_store[clamp_edge(req.line, pad, h) * MAX_WIDTH
                                        + clamp_edge(req.column, pad, w)];
          want.outside   = 1'b0;
          read_expect_q.push_back(want);
        end
      end
      // Track geometry registers; drop unknown indexes
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_SRC_COLS: begin
            width_reg = cfg_data[SIZE_W-1:0];
          end
          CFG_SRC_ROWS: begin
            height_reg = cfg_data[SIZE_W-1:0];
          end
          CFG_WINDOW_SIZE: begin
            window_reg = cfg_data[WIN_W-1:0];
          end
          default: begin
          end
        endcase
      end
    end
    reads_waiting <= read_expect_q.size();
  end

endmodule

// File: verif/replicate_border_padding_test.sv
// Testbench top for the replicate-border padding frame store: clock, reset, stimulus, verdict.
// Drives pixel writes, padded reads and geometry changes; padded_read_checker does the checks.
// Depends on rbp_pkg, replicate_border_padding and padded_read_checker.
module replicate_border_padding_test;
  timeunit 1ns;
  timeprecision 1ps;
  import rbp_pkg::*;

  localparam logic [CFG_INDEX_W-1:0] CFG_UNUSED = CFG_INDEX_W'(3);
  localparam int PHASE_ITEMS  = 50;
  localparam int WARMUP_ITEMS = 30;
  localparam int DRAIN_CYCLES = 16;
  localparam int HOLD_CYCLES  = 300;
  localparam int STALL_LIMIT  = 3000;
  localparam int IDLE_PCT     = 23;
  localparam int MAX_COORD    = 541;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   req_valid = 1'b0;
  logic                   req_ready;
  req_t                   req = '0;
  logic                   rsp_valid;
  logic                   rsp_ready = 1'b0;
  rsp_t                   rsp;
  logic                   cfg_valid = 1'b0;
  logic                   cfg_ready;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0]  cfg_data = '0;

  int unsigned mismatches;
  int unsigned reads_waiting;
  int unsigned reads_checked;
  int unsigned border_reads;

  // Stimulus-side view of the geometry and of which pixels hold data
  int unsigned eff_w = MAX_WIDTH;
  int unsigned eff_h = MAX_HEIGHT;
  int unsigned eff_k = 3;
  bit          painted [FRAME_DEPTH];
  int unsigned writes_sent = 0;
  int unsigned reads_sent = 0;
  int unsigned settings_seen = 1;
  logic        no_gaps = 1'b0;
  logic        squeeze = 1'b0;
  int unsigned quiet_cycles = 0;

  // Width, height and window words per phase; some saturate or get masked
  int unsigned geometry [8][3] = '{
    '{4, 3, 5}, '{1, 1, 31}, '{0, 0, 0}, '{1023, 7, 994},
    '{9, 512, 4}, '{512, 512, 1}, '{16, 16, 30}, '{6, 5, 3}
  };

  always #10 clk = ~clk;

  replicate_border_padding dut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  padded_read_checker read_check (
    .clk           (clk),
    .rst           (rst),
    .req_valid     (req_valid),
    .req_ready     (req_ready),
    .req           (req),
    .rsp_valid     (rsp_valid),
    .rsp_ready     (rsp_ready),
    .rsp           (rsp),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .mismatches    (mismatches),
    .reads_waiting (reads_waiting),
    .reads_checked (reads_checked),
    .border_reads  (border_reads)
  );

  // Count cycles in which no channel moves a word
  always @(posedge clk) begin
    if (rst || (req_valid && req_ready) || (rsp_valid && rsp_ready) ||
        (cfg_valid && cfg_ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
  end

  initial begin : watchdog
    wait (quiet_cycles >= STALL_LIMIT);
    $display("FAILURE");
    $finish;
  end

  // Response side: random stalls, one long hold-off once squeeze is raised
  initial begin : rsp_drain
    bit held = 1'b0;
    forever begin
      @(negedge clk);
      if (squeeze && !held) begin
        held = 1'b1;
        rsp_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
      end
      rsp_ready <= no_gaps || ($urandom_range(0, 99) >= IDLE_PCT);
    end
  end

  function automatic int unsigned limit(int unsigned v, int unsigned hi);
    if (v < 1) return 1;
    if (v > hi) return hi;
    return v;
  endfunction

  function automatic int unsigned edge_clamp(int unsigned p, int unsigned pad,
                                             int unsigned size);
    if (p < pad) return 0;
    if (p - pad >= size) return size - 1;
    return p - pad;
  endfunction

  // Pick a padded coordinate: anywhere, near either border, or inside
  function automatic int unsigned pick_coord(int unsigned span);
    int unsigned roll;
    int unsigned reach;
    roll  = $urandom_range(0, 9);
    reach = (eff_k < span) ? eff_k : span - 1;
    if (roll < 2) return $urandom_range(0, MAX_COORD);
    if (roll < 5) begin
      if ($urandom_range(0, 1)) return $urandom_range(0, reach);
      return span - 1 - $urandom_range(0, reach);
    end
    return $urandom_range(0, span - 1);
  endfunction

  // Offer one request word; called and returns at a falling edge
  task automatic offer_req(input req_t word);
    while (!no_gaps && $urandom_range(0, 99) < IDLE_PCT) begin
      req_valid <= 1'b0;
      @(negedge clk);
    end
    req       <= word;
    req_valid <= 1'b1;
    @(posedge clk);
    while (!req_ready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic put_pixel(input int unsigned col, input int unsigned row,
                           input int unsigned pix);
    req_t word;
    word.func     = FUNC_WRITE;
    word.column   = COORD_W'(col);
    word.line     = COORD_W'(row);
    word.pixel_in = PIXEL_W'(pix);
    if (col < eff_w && row < eff_h) painted[row * MAX_WIDTH + col] = 1'b1;
    writes_sent++;
    offer_req(word);
  endtask

  // Read a padded pixel, writing its source pixel first if it holds no data
  task automatic get_pixel(input int unsigned col, input int unsigned row);
    req_t        word;
    int unsigned sx;
    int unsigned sy;
    if (col < eff_w + eff_k - 1 && row < eff_h + eff_k - 1) begin
      sx = edge_clamp(col, eff_k / 2, eff_w);
      sy = edge_clamp(row, eff_k / 2, eff_h);
      if (!painted[sy * MAX_WIDTH + sx]) put_pixel(sx, sy, $urandom_range(0, 255));
    end
    word.func     = FUNC_READ;
    word.column   = COORD_W'(col);
    word.line     = COORD_W'(row);
    word.pixel_in = PIXEL_W'($urandom_range(0, 255));
    reads_sent++;
    offer_req(word);
  endtask

  task automatic random_item();
    if ($urandom_range(0, 99) < 35) begin
      if ($urandom_range(0, 6) == 0)
        put_pixel($urandom_range(0, MAX_COORD), $urandom_range(0, MAX_COORD),
                  $urandom_range(0, 255));
      else
        put_pixel($urandom_range(0, eff_w - 1), $urandom_range(0, eff_h - 1),
                  $urandom_range(0, 255));
    end else begin
      get_pixel(pick_coord(eff_w + eff_k - 1), pick_coord(eff_h + eff_k - 1));
    end
  endtask

  // Stop offering, wait for all reads to return, then let writes retire
  task automatic quiesce();
    req_valid <= 1'b0;
    while (reads_waiting != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input int unsigned val);
    cfg_index <= idx;
    cfg_data  <= CFG_DATA_W'(val);
    cfg_valid <= 1'b1;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic set_geometry(input int unsigned w, input int unsigned h,
                              input int unsigned k);
    quiesce();
    write_reg(CFG_SRC_COLS, w);
    write_reg(CFG_SRC_ROWS, h);
    write_reg(CFG_WINDOW_SIZE, k);
    write_reg(CFG_UNUSED, $urandom_range(0, 1023));
    cfg_valid <= 1'b0;
    eff_w = limit(w % 1024, MAX_WIDTH);
    eff_h = limit(h % 1024, MAX_HEIGHT);
    eff_k = limit(k % 32, MAX_WINDOW);
    settings_seen++;
  endtask

  initial begin : stimulus
    repeat (10) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Reset geometry: corners, dropped writes, border and outside reads
    put_pixel(0, 0, 8'h00);
    put_pixel(511, 0, 8'hFF);
    put_pixel(0, 511, 8'hA5);
    put_pixel(511, 511, 8'h5A);
    put_pixel(1, 1, 8'h3C);
    put_pixel(512, 5, 8'h77);
    put_pixel(5, 541, 8'h11);
    put_pixel(541, 541, 8'hFF);
    get_pixel(0, 0);
    get_pixel(1, 1);
    get_pixel(2, 2);
    get_pixel(513, 0);
    get_pixel(0, 513);
    get_pixel(512, 512);
    get_pixel(513, 513);
    get_pixel(514, 0);
    get_pixel(0, 514);
    get_pixel(541, 541);
    put_pixel(0, 0, 8'hC3);
    get_pixel(1, 0);
    repeat (WARMUP_ITEMS) random_item();

    // Sweep geometries; hold off responses in one phase, run gap-free in another
    for (int p = 0; p < 8; p++) begin
      set_geometry(geometry[p][0], geometry[p][1], geometry[p][2]);
      if (p == 1) squeeze <= 1'b1;
      if (p == 5) no_gaps <= 1'b1;
      repeat (PHASE_ITEMS) random_item();
      no_gaps <= 1'b0;
    end

    quiesce();
    $display("Covered %0d pixel writes and %0d padded reads over %0d geometries,",
             writes_sent, reads_sent, settings_seen);
    $display("with %0d responses checked, %0d of them beyond the padded border.",
             reads_checked, border_reads);
    if (mismatches == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
